[hdl/ilst_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package ilst_pkg;

  // default list depth
  localparam int unsigned DefCapacity = 256;

  // fixed field widths
  localparam int unsigned KindW   = 2;
  localparam int unsigned PosW    = 9;
  localparam int unsigned ValW    = 32;
  localparam int unsigned StatusW = 2;
  localparam int unsigned FoundW  = 8;
  localparam int unsigned CntOutW = 9;

  // request kinds
  localparam logic [KindW-1:0] ReqInsert = 2'd0;
  localparam logic [KindW-1:0] ReqRemove = 2'd1;
  localparam logic [KindW-1:0] ReqSearch = 2'd2;

  // result status codes
  localparam logic [StatusW-1:0] StOk    = 2'd0;
  localparam logic [StatusW-1:0] StRange = 2'd1;
  localparam logic [StatusW-1:0] StFull  = 2'd2;
  localparam logic [StatusW-1:0] StMiss  = 2'd3;

  // walk pointer start point
  typedef enum logic [1:0] {
    IdxPos,
    IdxPosInc,
    IdxZero
  } idx_sel_e;

  // controller to datapath
  typedef struct packed {
    logic                req_load;
    logic                idx_load;
    idx_sel_e            idx_sel;
    logic                walk;
    logic                pend;
    logic                wr_up;
    logic                wr_value;
    logic                cnt_inc;
    logic                cnt_dec;
    logic                res_load;
    logic [StatusW-1:0]  res_status;
    logic                res_hit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [KindW-1:0] kind;
    logic             ins_range;
    logic             rm_range;
    logic             full;
    logic             empty;
    logic             more;
    logic             rd_valid;
    logic             hit;
  } sts_t;

endpackage

`default_nettype wire

[hdl/ilst_dpath.sv]
`timescale 1ns / 1ps
`default_nettype none

module ilst_dpath #(
  parameter int unsigned Capacity = ilst_pkg::DefCapacity
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic [ilst_pkg::KindW-1:0]        req_type_i,
  input  wire logic [ilst_pkg::PosW-1:0]         position_i,
  input  wire logic signed [ilst_pkg::ValW-1:0]  item_value_i,
  input  wire ilst_pkg::cmd_t                    cmd_i,
  output ilst_pkg::sts_t                         sts_o,
  output logic [ilst_pkg::StatusW-1:0]           status_o,
  output logic [ilst_pkg::FoundW-1:0]            found_position_o,
  output logic [ilst_pkg::CntOutW-1:0]           entry_count_o
);

  localparam int unsigned AW   = $clog2(Capacity);
  localparam int unsigned CW   = $clog2(Capacity + 1);
  localparam int unsigned CmpW = (CW > ilst_pkg::PosW) ? CW : ilst_pkg::PosW;
  localparam int unsigned OutW = (CW > ilst_pkg::CntOutW) ? CW : ilst_pkg::CntOutW;
  localparam int unsigned FndW = (AW > ilst_pkg::FoundW) ? AW : ilst_pkg::FoundW;

  // latched request
  logic [ilst_pkg::KindW-1:0]  kind_q;
  logic [ilst_pkg::PosW-1:0]   pos_q;
  logic [ilst_pkg::ValW-1:0]   val_q;

  logic [CW-1:0]               count_q, count_d;
  logic [CW-1:0]               idx_q, idx_d;
  logic [CW-1:0]               idx_up, idx_dn;
  logic [AW-1:0]               idx_addr;
  logic                        rd_valid_q;
  logic                        wr_pend_q;
  logic [AW-1:0]               wr_addr_q;
  logic [AW-1:0]               rd_addr_q;
  logic [ilst_pkg::ValW-1:0]   rd_data_q;
  logic [ilst_pkg::ValW-1:0]   mem_q [Capacity];

  logic [ilst_pkg::StatusW-1:0] res_status_q;
  logic [ilst_pkg::FoundW-1:0]  res_found_q;

  logic [CmpW-1:0]             pos_ext, cnt_ext;
  logic [CW-1:0]               pos_trunc;
  logic [FndW-1:0]             rd_addr_ext;
  logic [OutW-1:0]             cnt_out_ext;

  assign pos_ext     = CmpW'(pos_q);
  assign cnt_ext     = CmpW'(count_q);
  assign pos_trunc   = pos_ext[CW-1:0];
  assign idx_up      = idx_q + CW'(1);
  assign idx_dn      = idx_q - CW'(1);
  assign idx_addr    = idx_q[AW-1:0];
  assign rd_addr_ext = FndW'(rd_addr_q);
  assign cnt_out_ext = OutW'(count_q);

  always_comb begin
    sts_o.kind      = kind_q;
    sts_o.ins_range = pos_ext > cnt_ext;
    sts_o.rm_range  = pos_ext >= cnt_ext;
    sts_o.full      = count_q == CW'(Capacity);
    sts_o.empty     = count_q == '0;
    sts_o.more      = idx_q < count_q;
    sts_o.rd_valid  = rd_valid_q;
    sts_o.hit       = rd_valid_q && (rd_data_q == val_q);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.req_load) begin
      kind_q <= req_type_i;
      pos_q  <= position_i;
      val_q  <= item_value_i;
    end
  end

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.idx_load) begin
      case (cmd_i.idx_sel)
        ilst_pkg::IdxPos:    idx_d = pos_trunc;
        ilst_pkg::IdxPosInc: idx_d = pos_trunc + CW'(1);
        default:             idx_d = '0;
      endcase
    end else if (cmd_i.walk) begin
      idx_d = idx_up;
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.cnt_inc) begin
      count_d = count_q + CW'(1);
    end else if (cmd_i.cnt_dec) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      idx_q      <= '0;
      rd_valid_q <= 1'b0;
      wr_pend_q  <= 1'b0;
    end else begin
      count_q    <= count_d;
      idx_q      <= idx_d;
      rd_valid_q <= cmd_i.walk;
      wr_pend_q  <= cmd_i.walk & cmd_i.pend;
    end
  end

  // shift pipeline: read one entry, write it one place over in the following cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.walk) begin
      rd_addr_q <= idx_addr;
      wr_addr_q <= cmd_i.wr_up ? idx_up[AW-1:0] : idx_dn[AW-1:0];
    end
  end

  // read-first memory, one write and one read a cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.walk) begin
      rd_data_q <= mem_q[idx_addr];
    end
    if (wr_pend_q) begin
      mem_q[wr_addr_q] <= rd_data_q;
    end else if (cmd_i.wr_value) begin
      mem_q[idx_addr] <= val_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      res_status_q <= cmd_i.res_status;
      res_found_q  <= cmd_i.res_hit ? rd_addr_ext[ilst_pkg::FoundW-1:0] : '0;
    end
  end

  assign status_o         = res_status_q;
  assign found_position_o = res_found_q;
  assign entry_count_o    = cnt_out_ext[ilst_pkg::CntOutW-1:0];

endmodule

`default_nettype wire

[hdl/ilst_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module ilst_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  input  wire ilst_pkg::sts_t  sts_i,
  output ilst_pkg::cmd_t       cmd_o
);

  localparam logic [3:0] StIdle     = 4'd0;
  localparam logic [3:0] StCheck    = 4'd1;
  localparam logic [3:0] StInsFirst = 4'd2;
  localparam logic [3:0] StInsWalk  = 4'd3;
  localparam logic [3:0] StInsDone  = 4'd4;
  localparam logic [3:0] StRmWalk   = 4'd5;
  localparam logic [3:0] StRmDone   = 4'd6;
  localparam logic [3:0] StSrWalk   = 4'd7;
  localparam logic [3:0] StOut      = 4'd8;

  logic [3:0] state_q, state_d;

  assign in_ready_o  = state_q == StIdle;
  assign out_valid_o = state_q == StOut;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.idx_sel    = ilst_pkg::IdxZero;
    cmd_o.res_status = ilst_pkg::StOk;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.req_load = 1'b1;
          state_d        = StCheck;
        end
      end
      StCheck: begin
        case (sts_i.kind)
          ilst_pkg::ReqInsert: begin
            if (sts_i.ins_range) begin
              cmd_o.res_load   = 1'b1;
              cmd_o.res_status = ilst_pkg::StRange;
              state_d          = StOut;
            end else if (sts_i.full) begin
              cmd_o.res_load   = 1'b1;
              cmd_o.res_status = ilst_pkg::StFull;
              state_d          = StOut;
            end else begin
              cmd_o.idx_load = 1'b1;
              cmd_o.idx_sel  = ilst_pkg::IdxPos;
              state_d        = StInsFirst;
            end
          end
          ilst_pkg::ReqRemove: begin
            if (sts_i.rm_range) begin
              cmd_o.res_load   = 1'b1;
              cmd_o.res_status = ilst_pkg::StRange;
              state_d          = StOut;
            end else begin
              cmd_o.idx_load = 1'b1;
              cmd_o.idx_sel  = ilst_pkg::IdxPosInc;
              state_d        = StRmWalk;
            end
          end
          ilst_pkg::ReqSearch: begin
            if (sts_i.empty) begin
              cmd_o.res_load   = 1'b1;
              cmd_o.res_status = ilst_pkg::StMiss;
              state_d          = StOut;
            end else begin
              cmd_o.idx_load = 1'b1;
              cmd_o.idx_sel  = ilst_pkg::IdxZero;
              state_d        = StSrWalk;
            end
          end
          default: begin
            cmd_o.res_load = 1'b1;
            state_d        = StOut;
          end
        endcase
      end
      StInsFirst: begin
        // new value lands at its slot while the old one is read out
        cmd_o.wr_value = 1'b1;
        if (sts_i.more) begin
          cmd_o.walk  = 1'b1;
          cmd_o.pend  = 1'b1;
          cmd_o.wr_up = 1'b1;
        end
        state_d = StInsWalk;
      end
      StInsWalk: begin
        if (sts_i.more) begin
          cmd_o.walk  = 1'b1;
          cmd_o.pend  = 1'b1;
          cmd_o.wr_up = 1'b1;
        end else begin
          state_d = StInsDone;
        end
      end
      StInsDone: begin
        cmd_o.cnt_inc  = 1'b1;
        cmd_o.res_load = 1'b1;
        state_d        = StOut;
      end
      StRmWalk: begin
        if (sts_i.more) begin
          cmd_o.walk = 1'b1;
          cmd_o.pend = 1'b1;
        end else begin
          state_d = StRmDone;
        end
      end
      StRmDone: begin
        cmd_o.cnt_dec  = 1'b1;
        cmd_o.res_load = 1'b1;
        state_d        = StOut;
      end
      StSrWalk: begin
        if (sts_i.hit) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_hit  = 1'b1;
          state_d        = StOut;
        end else if (sts_i.more) begin
          cmd_o.walk = 1'b1;
        end else if (!sts_i.rd_valid) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = ilst_pkg::StMiss;
          state_d          = StOut;
        end
      end
      StOut: begin
        if (out_ready_i) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

[hdl/indexed_list_store.sv]
// indexed_list_store: bounded ordered list with insert, remove and search by value
// throughput: one request at a time, set by the walk of one entry per cycle through the memory
// reset: async active-low clears the count and control; value memory is not cleared
`timescale 1ns / 1ps
`default_nettype none

module indexed_list_store #(
  parameter int unsigned CAPACITY = ilst_pkg::DefCapacity
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // request beat
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [47:0] s_axis_tdata_i,   // [8:0] position, [40:9] item_value, rest zero
  input  wire logic [1:0]  s_axis_tuser_i,   // [1:0] req_type
  // result beat
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [23:0]      m_axis_tdata_o    // [1:0] status, [9:2] found_position,
                                             // [18:10] entry_count, rest zero
);

  ilst_pkg::cmd_t                    cmd;
  ilst_pkg::sts_t                    sts;
  logic [ilst_pkg::StatusW-1:0]      status;
  logic [ilst_pkg::FoundW-1:0]       found_position;
  logic [ilst_pkg::CntOutW-1:0]      entry_count;

  // sequencer: accept, range check, walk, deliver
  ilst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // value memory, count, walk pointer and result register
  ilst_dpath #(
    .Capacity (CAPACITY)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req_type_i       (s_axis_tuser_i),
    .position_i       (s_axis_tdata_i[8:0]),
    .item_value_i     (s_axis_tdata_i[40:9]),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .status_o         (status),
    .found_position_o (found_position),
    .entry_count_o    (entry_count)
  );

  // result is held steady while the beat waits
  assign m_axis_tdata_o = {5'd0, entry_count, found_position, status};

endmodule

`default_nettype wire

[tb/indexed_list_store_tb.sv]
`timescale 1ns / 1ps

module indexed_list_store_tb;
  import ilst_pkg::*;

  localparam int unsigned Capacity  = DefCapacity;
  localparam logic [KindW-1:0] ReqUnused = 2'd3;
  localparam int unsigned QuietTail = 150;   // last beats sent with no idling
  localparam int unsigned HoldAt    = 400;   // accepted beats before the long receiver hold-off
  localparam int unsigned HoldLen   = 600;
  localparam int unsigned DrainWait = 300;   // longer than the slowest walk
  localparam int unsigned MaxReports = 10;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [PosW-1:0]  pos;
    logic [ValW-1:0]  val;
  } list_op_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [FoundW-1:0]  found;
    logic [CntOutW-1:0] count;
  } list_answer_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic [47:0] s_data = '0;
  logic [1:0]  s_user = '0;
  logic        m_ready = 1'b0;
  logic        s_ready;
  logic        m_valid;
  logic [23:0] m_data;

  always #6 clk_i = ~clk_i;

  indexed_list_store #(
    .CAPACITY(Capacity)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_data),
    .s_axis_tuser_i (s_user),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_data)
  );

  list_op_t     pending_ops[$];
  list_answer_t expected_answers[$];
  int unsigned  accepted_cnt = 0;
  int unsigned  total_ops = 0;
  int unsigned  mismatch_cnt = 0;
  int unsigned  gen_len = 0;        // list length as tracked while building stimulus
  logic [31:0]  value_pool[8];
  int unsigned  hold_left = 0;
  bit           hold_done = 1'b0;

  // predictor state
  logic [31:0]  list_vals[Capacity];
  int unsigned  list_len = 0;

  wire quiet = (accepted_cnt + QuietTail >= total_ops);

  function automatic list_answer_t apply_list_op(list_op_t op);
    list_answer_t ans;
    bit           hit;
    int unsigned  where;
    ans   = '0;
    hit   = 1'b0;
    where = 0;
    ans.status = StOk;
    case (op.kind)
      ReqInsert: begin
        if (op.pos > list_len) begin
          ans.status = StRange;
        end else if (list_len >= Capacity) begin
          ans.status = StFull;
        end else begin
          for (int unsigned i = list_len; i > op.pos; i--) list_vals[i] = list_vals[i-1];
          list_vals[op.pos] = op.val;
          list_len++;
        end
      end
      ReqRemove: begin
        if (op.pos >= list_len) begin
          ans.status = StRange;
        end else begin
          for (int unsigned i = op.pos; i + 1 < list_len; i++) list_vals[i] = list_vals[i+1];
          list_len--;
        end
      end
      ReqSearch: begin
        for (int unsigned i = 0; i < list_len; i++) begin
          if (list_vals[i] == op.val) begin
            hit   = 1'b1;
            where = i;
            break;
          end
        end
        if (hit) ans.found = where[FoundW-1:0];
        else ans.status = StMiss;
      end
      default: ;   // unused kind leaves everything alone
    endcase
    ans.count = list_len[CntOutW-1:0];
    return ans;
  endfunction

  // stimulus building, tracks the length so positions can be aimed
  task automatic queue_op(logic [KindW-1:0] kind, int unsigned pos, logic [31:0] val);
    list_op_t op;
    op.kind = kind;
    op.pos  = pos[PosW-1:0];
    op.val  = val;
    pending_ops.push_back(op);
    if (kind == ReqInsert && pos <= gen_len && gen_len < Capacity) gen_len++;
    else if (kind == ReqRemove && pos < gen_len) gen_len--;
  endtask

  function automatic logic [31:0] pick_value();
    if ($urandom_range(0, 99) < 70) return value_pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  task automatic random_ops(int unsigned n, int unsigned ins_pct, int unsigned rm_pct,
                            int unsigned srch_pct);
    int unsigned roll;
    int unsigned pos;
    repeat (n) begin
      roll = $urandom_range(0, 99);
      if (roll < ins_pct) begin
        case ($urandom_range(0, 3))
          0:       pos = 0;
          1:       pos = gen_len;
          default: pos = $urandom_range(0, gen_len);
        endcase
        queue_op(ReqInsert, pos, pick_value());
      end else if (roll < ins_pct + rm_pct) begin
        if (gen_len == 0) pos = 0;
        else if ($urandom_range(0, 3) == 0) pos = gen_len - 1;
        else pos = $urandom_range(0, gen_len - 1);
        queue_op(ReqRemove, pos, $urandom);
      end else if (roll < ins_pct + rm_pct + srch_pct) begin
        queue_op(ReqSearch, $urandom_range(0, 511), pick_value());
      end else begin
        // noise: unused kind or a position that is likely out of range
        case ($urandom_range(0, 2))
          0:       queue_op(ReqUnused, $urandom_range(0, 511), $urandom);
          1:       queue_op(ReqInsert, $urandom_range(0, 511), $urandom);
          default: queue_op(ReqRemove, $urandom_range(0, 511), $urandom);
        endcase
      end
    end
  endtask

  // request driver
  always @(posedge clk_i) begin
    bit       fire;
    bit       nxt_valid;
    list_op_t op;
    int       gap_left;
    if (rst_ni) begin
      fire = s_valid && s_ready;
      if (fire) begin
        expected_answers.push_back(apply_list_op(pending_ops.pop_front()));
        accepted_cnt <= accepted_cnt + 1;
      end
      if (!(s_valid && !fire)) begin
        nxt_valid = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_ops.size() > 0) begin
          if (!quiet && $urandom_range(0, 99) < 12) begin
            gap_left = $urandom_range(1, 6) - 1;
          end else begin
            op = pending_ops[0];
            nxt_valid = 1'b1;
            s_data <= {7'b0, op.val, op.pos};
            s_user <= op.kind;
          end
        end
        s_valid <= nxt_valid;
      end
    end else begin
      gap_left = 0;
    end
  end

  // long receiver hold-off, holds the result beat and so stalls the block's input
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && accepted_cnt >= HoldAt) begin
      hold_left <= HoldLen;
      hold_done <= 1'b1;
    end
  end

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatch_cnt++;
      if (mismatch_cnt <= MaxReports)
        $display("mismatch on %s: expected %0d, got %0d", name, want, got);
    end
  endtask

  // result monitor
  always @(posedge clk_i) begin
    list_answer_t want;
    int           stall_left;
    bit           nxt_ready;
    if (rst_ni) begin
      if (m_valid && m_ready) begin
        if (expected_answers.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MaxReports)
            $display("result beat with nothing expected: %h", m_data);
        end else begin
          want = expected_answers.pop_front();
          check_field("status", want.status, m_data[1:0]);
          check_field("found_position", want.found, m_data[9:2]);
          check_field("entry_count", want.count, m_data[18:10]);
        end
      end
      nxt_ready = 1'b0;
      if (hold_left > 0) begin
        nxt_ready = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
      end else if (!quiet && $urandom_range(0, 99) < 15) begin
        stall_left = $urandom_range(1, 6) - 1;
      end else begin
        nxt_ready = 1'b1;
      end
      m_ready <= nxt_ready;
    end else begin
      stall_left = 0;
    end
  end

  initial begin
    value_pool[0] = 32'h0000_0000;
    value_pool[1] = 32'h7fff_ffff;
    value_pool[2] = 32'h8000_0000;
    value_pool[3] = 32'hffff_ffff;
    for (int i = 4; i < 8; i++) value_pool[i] = $urandom;

    // directed: empty list cases, extremes, duplicates, every kind
    queue_op(ReqSearch, 0, 32'h0000_0000);
    queue_op(ReqRemove, 0, 32'h0000_0000);
    queue_op(ReqInsert, 1, 32'h1234_5678);
    queue_op(ReqInsert, 511, 32'hffff_ffff);
    queue_op(ReqInsert, 0, 32'h7fff_ffff);
    queue_op(ReqInsert, 1, 32'h8000_0000);
    queue_op(ReqInsert, 1, 32'h0000_0000);
    queue_op(ReqInsert, 0, 32'hffff_ffff);
    queue_op(ReqInsert, 4, 32'h7fff_ffff);     // duplicate at the tail
    queue_op(ReqSearch, 0, 32'h7fff_ffff);     // first match wins
    queue_op(ReqSearch, 0, 32'h8000_0000);
    queue_op(ReqSearch, 0, 32'h0001_2345);     // miss
    queue_op(ReqSearch, 511, 32'hffff_ffff);   // position ignored
    queue_op(ReqRemove, 5, 32'h0000_0000);     // one past the end
    queue_op(ReqRemove, 256, 32'h0000_0000);
    queue_op(ReqRemove, 2, 32'h0000_0000);
    queue_op(ReqRemove, 0, 32'h0000_0000);
    queue_op(ReqUnused, 511, 32'hffff_ffff);
    queue_op(ReqRemove, 2, 32'h0000_0000);     // last entry
    queue_op(ReqSearch, 0, 32'h7fff_ffff);
    queue_op(ReqInsert, 2, 32'hdead_beef);     // append at count
    queue_op(ReqInsert, 4, 32'h0000_0001);     // past the end

    // random: mixed, fill to full, stay near full, drain, probe the empty list, mixed
    random_ops(250, 55, 25, 15);
    while (gen_len < Capacity) random_ops(1, 90, 3, 5);
    random_ops(150, 50, 20, 25);
    while (gen_len > 0) random_ops(1, 5, 80, 12);
    random_ops(6, 0, 50, 30);
    random_ops(300, 45, 30, 20);
    total_ops = pending_ops.size();

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_ops.size() > 0 || expected_answers.size() > 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    if (mismatch_cnt == 0 && expected_answers.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // run limit, several times the slowest legal run
  initial begin
    #40_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
